FILE: src/co2fca_pkg.sv
// Shared types, widths and constants of the CO2 frame checker and averager.
package co2fca_pkg;

    localparam int COUNT_BITS = 16;
    localparam int PPM_W      = 16;
    localparam int TEMP_W     = 9;
    localparam int BYTE_W     = 8;
    localparam int OUT_CNT_W  = 16;
    localparam int SUM_W      = COUNT_BITS + PPM_W;
    localparam int STEP_W     = $clog2(SUM_W + 1);
    localparam int EXT_W      = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

    localparam logic [3:0]              FRAME_LEN    = 4'd9;
    localparam logic [3:0]              LAST_POS     = 4'd8;
    localparam logic [3:0]              FIRST_SUM    = 4'd1;
    localparam logic [3:0]              LAST_SUM     = 4'd7;
    localparam logic [3:0]              POS_PPM_HI   = 4'd2;
    localparam logic [3:0]              POS_PPM_LO   = 4'd3;
    localparam logic [3:0]              POS_TEMP     = 4'd4;
    localparam logic [3:0]              POS_STATUS   = 4'd5;
    localparam logic [PPM_W-1:0]        EXCLUDED_PPM = 16'd410;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 9'sd40;
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX    = '1;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_REPORT  = 2'd3
    } op_t;

    typedef enum logic {
        KIND_SINGLE  = 1'b0,
        KIND_AVERAGE = 1'b1
    } kind_t;

    typedef struct packed {
        logic                  start;
        logic [SUM_W-1:0]      dividend;
        logic [COUNT_BITS-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic [PPM_W-1:0] quotient;
    } div_stat_t;

    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(c);
        if (ext > EXT_W'({OUT_CNT_W{1'b1}}))
        begin
            return '1;
        end
        return ext[OUT_CNT_W-1:0];
    endfunction

endpackage

FILE: src/co2fca_if.sv
// Valid/ready channel interfaces for the request and result transfers.
interface co2fca_in_if import co2fca_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface co2fca_out_if import co2fca_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic                     valid_res;
    logic [PPM_W-1:0]         ppm;
    logic signed [TEMP_W-1:0] temperature;
    logic [OUT_CNT_W-1:0]     sample_count;

    modport source (output valid, output kind, output valid_res, output ppm,
                    output temperature, output sample_count, input ready);
    modport sink   (input valid, input kind, input valid_res, input ppm,
                    input temperature, input sample_count, output ready);
endinterface

FILE: src/co2fca_divider.sv
// Bit-serial restoring divider that forms the mean of the running ppm sum.
module co2fca_divider import co2fca_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  div_ctrl_t ctrl,
    output div_stat_t stat
);

    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] div_reg, div_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    logic [COUNT_BITS:0] shifted;
    logic [COUNT_BITS:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        diff      = shifted - {1'b0, div_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        if (ctrl.start)
        begin
            quo_next  = ctrl.dividend;
            rem_next  = '0;
            div_next  = ctrl.divisor;
            step_next = STEP_W'(SUM_W);
        end
        else if (step_reg != '0)
        begin
            if (!diff[COUNT_BITS])
            begin
                rem_next = diff[COUNT_BITS-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[COUNT_BITS-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.busy     = (step_reg != '0);
    assign stat.quotient = quo_reg[PPM_W-1:0];

endmodule

FILE: src/co2_frame_check_and_average.sv
// Top level of the CO2 sensor reply checker and running ppm averager.
//
// Requests arrive on the request channel: start of frame, one reply byte,
// reply timeout or report. Results leave on the result channel, one per
// timeout, per report and per ninth byte of an open frame; other requests
// give no result. A transfer happens when valid and ready are both high.
// Start, byte and timeout requests are handled at the transfer, and any
// result they give is registered in the cycle after the transfer.
// A report with samples in the running sum starts a one-bit-per-cycle
// divider over the 32-bit sum; its result is registered once the divider
// is done and the output register is free, and no request is taken
// before then. A report with no samples answers in the next cycle with the
// last reading.
// A single output register holds the pending result. While the receiver
// stalls, a new request is taken only once that register is freed in the
// same cycle. Reset closes any frame, clears the sums and last reading,
// and empties the output register.
module co2_frame_check_and_average import co2fca_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    co2fca_in_if.sink     request,
    co2fca_out_if.source  result
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DIVIDE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]               pos_reg, pos_next;
    logic [BYTE_W-1:0]        checksum_reg, checksum_next;
    logic [PPM_W-1:0]         ppm_cap_reg, ppm_cap_next;
    logic [BYTE_W-1:0]        temp_cap_reg, temp_cap_next;
    logic [BYTE_W-1:0]        status_cap_reg, status_cap_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [COUNT_BITS-1:0]    total_reg, total_next;
    logic [PPM_W-1:0]         last_ppm_reg, last_ppm_next;
    logic                     last_valid_reg, last_valid_next;
    logic signed [TEMP_W-1:0] last_temp_reg, last_temp_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_kind_reg, out_kind_next;
    logic                     out_vres_reg, out_vres_next;
    logic [PPM_W-1:0]         out_ppm_reg, out_ppm_next;
    logic signed [TEMP_W-1:0] out_temp_reg, out_temp_next;
    logic [OUT_CNT_W-1:0]     out_cnt_reg, out_cnt_next;

    div_ctrl_t div_ctrl;
    div_stat_t div_stat;

    logic              slot_free;
    logic              accept;
    logic              emit;
    logic              emit_kind;
    logic [BYTE_W-1:0] expect_sum;
    logic [PPM_W-1:0]  reading;

    co2fca_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    assign slot_free     = !out_valid_reg || result.ready;
    assign request.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept        = request.valid && request.ready;
    assign expect_sum    = BYTE_W'(8'd0 - checksum_reg);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        checksum_next   = checksum_reg;
        ppm_cap_next    = ppm_cap_reg;
        temp_cap_next   = temp_cap_reg;
        status_cap_next = status_cap_reg;
        sum_next        = sum_reg;
        total_next      = total_reg;
        last_ppm_next   = last_ppm_reg;
        last_valid_next = last_valid_reg;
        last_temp_next  = last_temp_reg;
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = sum_reg;
        div_ctrl.divisor  = total_reg;
        emit      = 1'b0;
        emit_kind = KIND_SINGLE;
        reading   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.operation)
                        OP_START:
                        begin
                            pos_next        = '0;
                            checksum_next   = '0;
                            ppm_cap_next    = '0;
                            temp_cap_next   = '0;
                            status_cap_next = '0;
                        end
                        OP_BYTE:
                        begin
                            if (pos_reg < FRAME_LEN)
                            begin
                                if (pos_reg >= FIRST_SUM && pos_reg <= LAST_SUM)
                                begin
                                    checksum_next = checksum_reg + request.data_byte;
                                end
                                if (pos_reg == POS_PPM_HI)
                                begin
                                    ppm_cap_next = {request.data_byte, ppm_cap_reg[7:0]};
                                end
                                else if (pos_reg == POS_PPM_LO)
                                begin
                                    ppm_cap_next = {ppm_cap_reg[15:8], request.data_byte};
                                end
                                else if (pos_reg == POS_TEMP)
                                begin
                                    temp_cap_next = request.data_byte;
                                end
                                else if (pos_reg == POS_STATUS)
                                begin
                                    status_cap_next = request.data_byte;
                                end
                                if (pos_reg == LAST_POS)
                                begin
                                    pos_next = FRAME_LEN;
                                    emit     = 1'b1;
                                    if (expect_sum == request.data_byte
                                        && status_cap_reg == '0)
                                    begin
                                        reading        = ppm_cap_reg;
                                        last_temp_next = TEMP_W'($signed({1'b0, temp_cap_reg})
                                                                 - TEMP_OFFSET);
                                    end
                                    last_ppm_next = reading;
                                    if (reading != '0 && reading != EXCLUDED_PPM)
                                    begin
                                        last_valid_next = 1'b1;
                                        if (total_reg < COUNT_MAX)
                                        begin
                                            sum_next   = sum_reg + SUM_W'(reading);
                                            total_next = total_reg + COUNT_BITS'(1);
                                        end
                                    end
                                    else
                                    begin
                                        last_valid_next = 1'b0;
                                        sum_next        = '0;
                                        total_next      = '0;
                                    end
                                end
                                else
                                begin
                                    pos_next = pos_reg + 4'd1;
                                end
                            end
                        end
                        OP_TIMEOUT:
                        begin
                            pos_next        = FRAME_LEN;
                            last_ppm_next   = '0;
                            last_valid_next = 1'b0;
                            sum_next        = '0;
                            total_next      = '0;
                            emit            = 1'b1;
                        end
                        OP_REPORT:
                        begin
                            if (total_reg != '0)
                            begin
                                div_ctrl.start = 1'b1;
                                state_next     = ST_DIVIDE;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                emit_kind = KIND_AVERAGE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIVIDE:
            begin
                if (!div_stat.busy && slot_free)
                begin
                    last_ppm_next   = div_stat.quotient;
                    last_valid_next = 1'b1;
                    emit            = 1'b1;
                    emit_kind       = KIND_AVERAGE;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_vres_next  = out_vres_reg;
        out_ppm_next   = out_ppm_reg;
        out_temp_next  = out_temp_reg;
        out_cnt_next   = out_cnt_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_vres_next  = last_valid_next;
            out_ppm_next   = last_ppm_next;
            out_temp_next  = last_temp_next;
            out_cnt_next   = sat_count(total_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= FRAME_LEN;
            checksum_reg   <= '0;
            ppm_cap_reg    <= '0;
            temp_cap_reg   <= '0;
            status_cap_reg <= '0;
            sum_reg        <= '0;
            total_reg      <= '0;
            last_ppm_reg   <= '0;
            last_valid_reg <= 1'b0;
            last_temp_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            checksum_reg   <= checksum_next;
            ppm_cap_reg    <= ppm_cap_next;
            temp_cap_reg   <= temp_cap_next;
            status_cap_reg <= status_cap_next;
            sum_reg        <= sum_next;
            total_reg      <= total_next;
            last_ppm_reg   <= last_ppm_next;
            last_valid_reg <= last_valid_next;
            last_temp_reg  <= last_temp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_vres_reg <= out_vres_next;
        out_ppm_reg  <= out_ppm_next;
        out_temp_reg <= out_temp_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = out_kind_reg;
    assign result.valid_res    = out_vres_reg;
    assign result.ppm          = out_ppm_reg;
    assign result.temperature  = out_temp_reg;
    assign result.sample_count = out_cnt_reg;

endmodule
